FILE: rtl/mcid_pkg.sv
package mcid_pkg;

   // Field widths of one beat
   localparam int unsigned ChannelW = 4;
   localparam int unsigned LevelW   = 8;
   localparam int unsigned MaskW    = 16;

   // Configuration port
   localparam int unsigned CsrAddrW = 4;
   localparam int unsigned CsrDataW = 32;

   localparam logic [LevelW-1:0] LevelMax = {LevelW{1'b1}};

   // Register reset values
   localparam logic [LevelW-1:0] HighThresholdReset = 8'd20;
   localparam logic [LevelW-1:0] LowThresholdReset  = 8'd0;
   localparam logic [LevelW-1:0] RiseStepReset      = 8'd2;

   typedef enum logic [1:0] {
      REG_HIGH_THRESHOLD = 2'd0,
      REG_LOW_THRESHOLD  = 2'd1,
      REG_RISE_STEP      = 2'd2,
      REG_UNUSED         = 2'd3
   } reg_index_type;

   typedef enum logic {
      FUNC_SAMPLE = 1'b0,
      FUNC_QUERY  = 1'b1
   } func_type;

   typedef struct packed {
      logic [LevelW-1:0] high_threshold;
      logic [LevelW-1:0] low_threshold;
      logic [LevelW-1:0] rise_step;
   } cfg_type;

   typedef struct packed {
      logic [LevelW-1:0] level;
      logic              blocked;
   } chan_state_type;

endpackage

FILE: rtl/mcid_req_if.sv
interface mcid_req_if
   import mcid_pkg::*;
();
   logic                valid;
   logic                ready;
   logic                func;
   logic [ChannelW-1:0] channel;
   logic                light_seen;
   logic [MaskW-1:0]    query_mask;

   modport source (output valid, func, channel, light_seen, query_mask, input ready);
   modport sink   (input valid, func, channel, light_seen, query_mask, output ready);
endinterface

FILE: rtl/mcid_rsp_if.sv
interface mcid_rsp_if
   import mcid_pkg::*;
();
   logic              valid;
   logic              ready;
   logic              channel_blocked;
   logic [LevelW-1:0] level;
   logic              all_free;

   modport source (output valid, channel_blocked, level, all_free, input ready);
   modport sink   (input valid, channel_blocked, level, all_free, output ready);
endinterface

FILE: rtl/mcid_chan_update.sv
module mcid_chan_update
   import mcid_pkg::*;
(
   input  cfg_type        cfg,
   input  chan_state_type cur,
   input  logic           light_seen,
   output chan_state_type nxt
);

   logic [LevelW:0]   sum;
   logic [LevelW-1:0] lvl;

   // Integrate: rise on dark below the high mark, fall on light above the low mark
   always_comb begin
      sum = {1'b0, cur.level} + {1'b0, cfg.rise_step};
      lvl = cur.level;
      if (!light_seen && (cur.level < cfg.high_threshold)) begin
         lvl = sum[LevelW] ? LevelMax : sum[LevelW-1:0];
      end
      if (light_seen && (cur.level > cfg.low_threshold)) begin
         lvl = cur.level - LevelW'(1);
      end
   end

   // Hysteresis: set test first, clear test wins on the same level
   always_comb begin
      nxt.level   = lvl;
      nxt.blocked = cur.blocked;
      if (lvl >= cfg.high_threshold) begin
         nxt.blocked = 1'b1;
      end
      if (lvl <= cfg.low_threshold) begin
         nxt.blocked = 1'b0;
      end
   end

endmodule

FILE: rtl/multi_channel_integrator_debounce.sv
// A beat is taken into the input register, then moves to the result register and rsp
//   once the result register is free or being drained; the per-channel update is a
//   single add/compare pass. Throughput: one beat per cycle unless rsp stalls.
// A stalled result register holds while the input register still takes one more beat.
// Reset (synchronous, active high) zeroes all integrators and blocked flags,
//   empties both registers and loads the threshold and step registers with defaults.
module multi_channel_integrator_debounce
   import mcid_pkg::*;
#(
   parameter int unsigned NUM_CHANNELS = 14
) (
   input  logic                clock,
   input  logic                reset,
   mcid_req_if.sink            req,
   mcid_rsp_if.source          rsp,
   input  logic                csr_psel,
   input  logic                csr_penable,
   input  logic                csr_pwrite,
   input  logic [CsrAddrW-1:0] csr_paddr,
   input  logic [CsrDataW-1:0] csr_pwdata,
   output logic [CsrDataW-1:0] csr_prdata,
   output logic                csr_pready
);

   // Configuration registers
   cfg_type       cfg_ff, cfg_in;
   reg_index_type csr_idx;
   logic          csr_wr;

   // Channel state
   logic [LevelW-1:0]       level_ff [NUM_CHANNELS];
   logic [LevelW-1:0]       level_in [NUM_CHANNELS];
   logic [NUM_CHANNELS-1:0] blocked_ff, blocked_in;

   // Input register
   logic                s1_valid_ff, s1_valid_in;
   logic                s1_func_ff, s1_func_in;
   logic [ChannelW-1:0] s1_channel_ff, s1_channel_in;
   logic                s1_light_ff, s1_light_in;
   logic [MaskW-1:0]    s1_mask_ff, s1_mask_in;

   // Result register
   logic              rsp_valid_ff, rsp_valid_in;
   logic              rsp_blocked_ff, rsp_blocked_in;
   logic [LevelW-1:0] rsp_level_ff, rsp_level_in;
   logic              rsp_free_ff, rsp_free_in;

   logic           advance;
   logic           in_range;
   logic           do_sample;
   logic           all_free;
   chan_state_type cur, nxt;

   // Register access decode
   assign csr_idx    = reg_index_type'(csr_paddr[CsrAddrW-1:2]);
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite;
   assign csr_pready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_wr) begin
         case (csr_idx)
            REG_HIGH_THRESHOLD: cfg_in.high_threshold = csr_pwdata[LevelW-1:0];
            REG_LOW_THRESHOLD:  cfg_in.low_threshold  = csr_pwdata[LevelW-1:0];
            REG_RISE_STEP:      cfg_in.rise_step      = csr_pwdata[LevelW-1:0];
            default:            cfg_in = cfg_ff;
         endcase
      end
   end

   always_comb begin
      case (csr_idx)
         REG_HIGH_THRESHOLD: csr_prdata = CsrDataW'(cfg_ff.high_threshold);
         REG_LOW_THRESHOLD:  csr_prdata = CsrDataW'(cfg_ff.low_threshold);
         REG_RISE_STEP:      csr_prdata = CsrDataW'(cfg_ff.rise_step);
         default:            csr_prdata = '0;
      endcase
   end

   // Handshake: advance when the result register is free or being drained
   assign advance   = s1_valid_ff && (!rsp_valid_ff || rsp.ready);
   assign req.ready = !s1_valid_ff || advance;

   // Hold the beat in the input register
   always_comb begin
      s1_valid_in   = s1_valid_ff;
      s1_func_in    = s1_func_ff;
      s1_channel_in = s1_channel_ff;
      s1_light_in   = s1_light_ff;
      s1_mask_in    = s1_mask_ff;
      if (req.ready) begin
         s1_valid_in   = req.valid;
         s1_func_in    = req.func;
         s1_channel_in = req.channel;
         s1_light_in   = req.light_seen;
         s1_mask_in    = req.query_mask;
      end
   end

   // Select the addressed channel
   assign in_range  = {1'b0, s1_channel_ff} < (ChannelW+1)'(NUM_CHANNELS);
   assign do_sample = advance && (s1_func_ff == FUNC_SAMPLE) && in_range;

   always_comb begin
      cur = '0;
      for (int unsigned i = 0; i < NUM_CHANNELS; i++) begin
         if (s1_channel_ff == ChannelW'(i)) begin
            cur.level   = level_ff[i];
            cur.blocked = blocked_ff[i];
         end
      end
   end

   mcid_chan_update u_update (
      .cfg        (cfg_ff),
      .cur        (cur),
      .light_seen (s1_light_ff),
      .nxt        (nxt)
   );

   // Write back the addressed channel
   always_comb begin
      blocked_in = blocked_ff;
      for (int unsigned i = 0; i < NUM_CHANNELS; i++) begin
         level_in[i] = level_ff[i];
         if (do_sample && (s1_channel_ff == ChannelW'(i))) begin
            level_in[i]   = nxt.level;
            blocked_in[i] = nxt.blocked;
         end
      end
   end

   // Masked query over all flags
   assign all_free = ~|(blocked_ff & s1_mask_ff[NUM_CHANNELS-1:0]);

   // Load or drain the result register
   always_comb begin
      rsp_valid_in   = rsp_valid_ff && !rsp.ready;
      rsp_blocked_in = rsp_blocked_ff;
      rsp_level_in   = rsp_level_ff;
      rsp_free_in    = rsp_free_ff;
      if (advance) begin
         rsp_valid_in   = 1'b1;
         rsp_blocked_in = 1'b0;
         rsp_level_in   = '0;
         rsp_free_in    = 1'b0;
         if (s1_func_ff == FUNC_QUERY) begin
            rsp_free_in = all_free;
         end else if (in_range) begin
            rsp_blocked_in = nxt.blocked;
            rsp_level_in   = nxt.level;
         end
      end
   end

   assign rsp.valid           = rsp_valid_ff;
   assign rsp.channel_blocked = rsp_blocked_ff;
   assign rsp.level           = rsp_level_ff;
   assign rsp.all_free        = rsp_free_ff;

   // Control and state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.high_threshold <= HighThresholdReset;
         cfg_ff.low_threshold  <= LowThresholdReset;
         cfg_ff.rise_step      <= RiseStepReset;
         s1_valid_ff           <= 1'b0;
         rsp_valid_ff          <= 1'b0;
         blocked_ff            <= '0;
         for (int unsigned i = 0; i < NUM_CHANNELS; i++) begin
            level_ff[i] <= '0;
         end
      end else begin
         cfg_ff       <= cfg_in;
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         blocked_ff   <= blocked_in;
         for (int unsigned i = 0; i < NUM_CHANNELS; i++) begin
            level_ff[i] <= level_in[i];
         end
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      s1_func_ff     <= s1_func_in;
      s1_channel_ff  <= s1_channel_in;
      s1_light_ff    <= s1_light_in;
      s1_mask_ff     <= s1_mask_in;
      rsp_blocked_ff <= rsp_blocked_in;
      rsp_level_ff   <= rsp_level_in;
      rsp_free_ff    <= rsp_free_in;
   end

endmodule
